// ===== hdl/mcct_pkg.sv =====
// Shared types and constants for the moving circle contact time block.
// Used by every module under hdl; depends on nothing.
package mcct_pkg;

    localparam int COORD_WIDTH_DEF = 16;  // default coordinate width
    localparam int FRAC_BITS       = 16;  // fraction bits of the contact time
    localparam int TIME_WIDTH      = 24;  // width of the contact time code

    typedef enum logic [2:0] {
        OUT_OVERLAP    = 3'd0,
        OUT_NO_MOTION  = 3'd1,
        OUT_SEPARATING = 3'd2,
        OUT_NO_ROOT    = 3'd3,
        OUT_CONTACT    = 3'd4
    } outcome_t;

    typedef struct packed {
        logic     valid;
        outcome_t outcome;
    } ctl_t;

endpackage

// ===== hdl/moving_circle_contact_time.sv =====
// Top level of the moving circle contact time block.
// Depends on mcct_pkg, mcct_front, mcct_sqrt_cell and mcct_div_cell.
//
// Swept contact test of two moving circles. Each word on the s_ channel
// carries both circles and both motion vectors; each carries exactly one
// result word on the m_: the outcome, a hit flag and the first contact time
// (unsigned Q8.16, saturating, zero unless the circles meet ahead).
// Throughput: one word per cycle while m_tready does not stall the pipeline.
// Stages: 7 front stages, one root bit per cell over 2*COORD_WIDTH+18
// square root cells, one stage for the numerator, 25 divider cells
// (one quotient bit each, the first one detecting saturation) and the
// output register.
// The whole pipeline advances together; when the receiver holds m_tready low
// with a word waiting, every stage holds and s_tready drops until it is taken.
// Reset (aresetn low, synchronous) drops all words in flight. The block has
// no state between words.
module moving_circle_contact_time #(
    parameter int COORD_WIDTH = mcct_pkg::COORD_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // own_x, own_y, own_radius, other_x, other_y, other_radius,
    // vel_a_x, vel_a_y, vel_b_x, vel_b_y, zero fill
    input  logic [((10*COORD_WIDTH-2+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // time_first
    output logic [mcct_pkg::TIME_WIDTH-1:0] m_tdata,
    // hit, outcome
    output logic [3:0] m_tuser
);
    localparam int W   = COORD_WIDTH;
    localparam int AW  = 2 * W + 2;
    localparam int DW  = 2 * AW;
    localparam int FB  = mcct_pkg::FRAC_BITS;
    localparam int TW  = mcct_pkg::TIME_WIDTH;
    localparam int RB  = AW + FB;
    localparam int DV  = AW + TW + 1;
    localparam int NDV = TW + 1;

    logic en;

    mcct_pkg::ctl_t sq_ctl  [RB+1];
    logic [DW-1:0]  sq_d    [RB+1];
    logic [RB:0]    sq_rem  [RB+1];
    logic [RB-1:0]  sq_root [RB+1];
    logic [2*AW-1:0] sq_side [RB+1];
    logic [AW-1:0]  fr_nb, fr_a;

    mcct_pkg::ctl_t nm_ctl_reg;
    logic [AW-1:0]  nm_a_reg;
    logic [DV-1:0]  nm_n_reg;

    mcct_pkg::ctl_t dv_ctl [NDV+1];
    logic [AW-1:0]  dv_a   [NDV+1];
    logic [DV-1:0]  dv_rem [NDV+1];
    logic [TW:0]    dv_q   [NDV+1];

    logic                  out_valid_reg, out_hit_reg;
    mcct_pkg::outcome_t    out_outcome_reg;
    logic [TW-1:0]         out_time_reg, out_time_next;
    logic                  out_hit_next;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    mcct_front #(.COORD_WIDTH(W)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .valid_i      (s_tvalid),
        .own_x        (s_tdata[W-1:0]),
        .own_y        (s_tdata[2*W-1:W]),
        .own_radius   (s_tdata[3*W-2:2*W]),
        .other_x      (s_tdata[4*W-2:3*W-1]),
        .other_y      (s_tdata[5*W-2:4*W-1]),
        .other_radius (s_tdata[6*W-3:5*W-1]),
        .vel_a_x      (s_tdata[7*W-3:6*W-2]),
        .vel_a_y      (s_tdata[8*W-3:7*W-2]),
        .vel_b_x      (s_tdata[9*W-3:8*W-2]),
        .vel_b_y      (s_tdata[10*W-3:9*W-2]),
        .ctl_o        (sq_ctl[0]),
        .d_o          (sq_d[0]),
        .nb_o         (fr_nb),
        .a_o          (fr_a)
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = {fr_nb, fr_a};

    generate
        for (genvar i = 0; i < RB; i++) begin : g_sqrt
            mcct_sqrt_cell #(.DW(DW), .RB(RB), .STEP(i), .SW(2*AW)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .ctl_i   (sq_ctl[i]),
                .d_i     (sq_d[i]),
                .rem_i   (sq_rem[i]),
                .root_i  (sq_root[i]),
                .side_i  (sq_side[i]),
                .ctl_o   (sq_ctl[i+1]),
                .d_o     (sq_d[i+1]),
                .rem_o   (sq_rem[i+1]),
                .root_o  (sq_root[i+1]),
                .side_o  (sq_side[i+1])
            );
        end
    endgenerate

    // numerator: -b scaled to the time fraction, minus the truncated root
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nm_ctl_reg <= '0;
        end else if (en) begin
            nm_ctl_reg <= sq_ctl[RB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nm_a_reg <= sq_side[RB][AW-1:0];
            nm_n_reg <= {{(DV-AW-FB){1'b0}}, sq_side[RB][2*AW-1:AW], {FB{1'b0}}}
                      - {{(DV-RB){1'b0}}, sq_root[RB]};
        end
    end

    assign dv_ctl[0] = nm_ctl_reg;
    assign dv_a[0]   = nm_a_reg;
    assign dv_rem[0] = nm_n_reg;
    assign dv_q[0]   = '0;

    generate
        for (genvar k = 0; k < NDV; k++) begin : g_div
            mcct_div_cell #(.AW(AW), .DV(DV), .SHIFT(TW - k)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .ctl_i   (dv_ctl[k]),
                .a_i     (dv_a[k]),
                .rem_i   (dv_rem[k]),
                .q_i     (dv_q[k]),
                .ctl_o   (dv_ctl[k+1]),
                .a_o     (dv_a[k+1]),
                .rem_o   (dv_rem[k+1]),
                .q_o     (dv_q[k+1])
            );
        end
    endgenerate

    always_comb begin
        out_hit_next  = dv_ctl[NDV].outcome == mcct_pkg::OUT_OVERLAP
                     || dv_ctl[NDV].outcome == mcct_pkg::OUT_CONTACT;
        out_time_next = '0;
        if (dv_ctl[NDV].outcome == mcct_pkg::OUT_CONTACT) begin
            // top quotient bit set means the quotient does not fit: saturate
            out_time_next = dv_q[NDV][TW] ? {TW{1'b1}} : dv_q[NDV][TW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_ctl[NDV].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_hit_reg     <= out_hit_next;
            out_outcome_reg <= dv_ctl[NDV].outcome;
            out_time_reg    <= out_time_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_time_reg;
    assign m_tuser  = {out_outcome_reg, out_hit_reg};

    a_hit_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (out_outcome_reg == mcct_pkg::OUT_OVERLAP
                                  || out_outcome_reg == mcct_pkg::OUT_CONTACT)))
        else $error("hit flag disagrees with outcome");

    a_time_only_contact: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata != '0) |-> (out_outcome_reg == mcct_pkg::OUT_CONTACT))
        else $error("nonzero time without contact");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    a_reset_flush: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word survived reset");

endmodule

// ===== hdl/mcct_front.sv =====
// Front pipeline: differences, products, quadratic coefficients and discriminant.
// Depends on mcct_pkg.
module mcct_front #(
    parameter int COORD_WIDTH = mcct_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          valid_i,
    input  logic signed [COORD_WIDTH-1:0] own_x,
    input  logic signed [COORD_WIDTH-1:0] own_y,
    input  logic        [COORD_WIDTH-2:0] own_radius,
    input  logic signed [COORD_WIDTH-1:0] other_x,
    input  logic signed [COORD_WIDTH-1:0] other_y,
    input  logic        [COORD_WIDTH-2:0] other_radius,
    input  logic signed [COORD_WIDTH-1:0] vel_a_x,
    input  logic signed [COORD_WIDTH-1:0] vel_a_y,
    input  logic signed [COORD_WIDTH-1:0] vel_b_x,
    input  logic signed [COORD_WIDTH-1:0] vel_b_y,
    output mcct_pkg::ctl_t                ctl_o,
    output logic [4*COORD_WIDTH+3:0]      d_o,
    output logic [2*COORD_WIDTH+1:0]      nb_o,
    output logic [2*COORD_WIDTH+1:0]      a_o
);
    localparam int W  = COORD_WIDTH;
    localparam int H  = W + 1;
    localparam int AW = 2 * H;
    localparam int BW = AW + 1;
    localparam int DW = 2 * AW;

    // stage 1
    mcct_pkg::ctl_t        c1_reg;
    logic signed [W:0]     sx_reg, sy_reg, vx_reg, vy_reg;
    logic        [W-1:0]   rs_reg;
    // stage 2
    mcct_pkg::ctl_t        c2_reg;
    logic signed [AW-1:0]  sxx_reg, syy_reg, vxx_reg, vyy_reg, vxsx_reg, vysy_reg;
    logic        [2*W-1:0] rr2_reg;
    // stage 3
    mcct_pkg::ctl_t        c3_reg;
    logic        [AW-1:0]  ss_reg, a3_reg;
    logic signed [BW-1:0]  b_reg;
    logic        [2*W-1:0] rr3_reg;
    // stage 4
    mcct_pkg::ctl_t        c4_reg, c4_next;
    logic        [AW-1:0]  cc_reg, a4_reg, nb4_reg;
    logic signed [BW-1:0]  nb_full;
    // stage 5
    mcct_pkg::ctl_t        c5_reg;
    logic        [AW-1:0]  a5_reg, nb5_reg;
    logic        [AW-1:0]  nhh_reg, nhl_reg, nll_reg, ahch_reg, ahcl_reg, alch_reg, alcl_reg;
    // stage 6
    mcct_pkg::ctl_t        c6_reg;
    logic        [AW-1:0]  a6_reg, nb6_reg;
    logic        [DW-1:0]  nb2_reg, ac_reg;
    // stage 7
    mcct_pkg::ctl_t        c7_reg, c7_next;
    logic        [AW-1:0]  a7_reg, nb7_reg;
    logic        [DW-1:0]  d_reg;

    always_comb begin
        nb_full = -b_reg;
        c4_next = c3_reg;
        if (ss_reg < {2'b00, rr3_reg}) begin
            c4_next.outcome = mcct_pkg::OUT_OVERLAP;
        end else if (a3_reg == '0) begin
            c4_next.outcome = mcct_pkg::OUT_NO_MOTION;
        end else if (!b_reg[BW-1]) begin
            c4_next.outcome = mcct_pkg::OUT_SEPARATING;
        end else begin
            c4_next.outcome = mcct_pkg::OUT_CONTACT;
        end
        c7_next = c6_reg;
        if (c6_reg.outcome == mcct_pkg::OUT_CONTACT && nb2_reg < ac_reg) begin
            c7_next.outcome = mcct_pkg::OUT_NO_ROOT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
            c7_reg <= '0;
        end else if (en) begin
            c1_reg.valid   <= valid_i;
            c1_reg.outcome <= mcct_pkg::OUT_CONTACT;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c4_next;
            c5_reg <= c4_reg;
            c6_reg <= c5_reg;
            c7_reg <= c7_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg <= $signed({own_x[W-1], own_x}) - $signed({other_x[W-1], other_x});
            sy_reg <= $signed({own_y[W-1], own_y}) - $signed({other_y[W-1], other_y});
            vx_reg <= $signed({vel_b_x[W-1], vel_b_x}) - $signed({vel_a_x[W-1], vel_a_x});
            vy_reg <= $signed({vel_b_y[W-1], vel_b_y}) - $signed({vel_a_y[W-1], vel_a_y});
            rs_reg <= {1'b0, own_radius} + {1'b0, other_radius};

            sxx_reg  <= sx_reg * sx_reg;
            syy_reg  <= sy_reg * sy_reg;
            vxx_reg  <= vx_reg * vx_reg;
            vyy_reg  <= vy_reg * vy_reg;
            vxsx_reg <= vx_reg * sx_reg;
            vysy_reg <= vy_reg * sy_reg;
            rr2_reg  <= rs_reg * rs_reg;

            ss_reg  <= $unsigned(sxx_reg) + $unsigned(syy_reg);
            a3_reg  <= $unsigned(vxx_reg) + $unsigned(vyy_reg);
            b_reg   <= $signed({vxsx_reg[AW-1], vxsx_reg}) + $signed({vysy_reg[AW-1], vysy_reg});
            rr3_reg <= rr2_reg;

            cc_reg  <= ss_reg - {2'b00, rr3_reg};
            a4_reg  <= a3_reg;
            nb4_reg <= nb_full[AW-1:0];

            // split both products into half-width partial products
            nhh_reg  <= nb4_reg[AW-1:H] * nb4_reg[AW-1:H];
            nhl_reg  <= nb4_reg[AW-1:H] * nb4_reg[H-1:0];
            nll_reg  <= nb4_reg[H-1:0]  * nb4_reg[H-1:0];
            ahch_reg <= a4_reg[AW-1:H]  * cc_reg[AW-1:H];
            ahcl_reg <= a4_reg[AW-1:H]  * cc_reg[H-1:0];
            alch_reg <= a4_reg[H-1:0]   * cc_reg[AW-1:H];
            alcl_reg <= a4_reg[H-1:0]   * cc_reg[H-1:0];
            a5_reg   <= a4_reg;
            nb5_reg  <= nb4_reg;

            nb2_reg <= {nhh_reg, {AW{1'b0}}}
                     + {{(H-1){1'b0}}, nhl_reg, {(H+1){1'b0}}}
                     + {{AW{1'b0}}, nll_reg};
            ac_reg  <= {ahch_reg, {AW{1'b0}}}
                     + {{H{1'b0}}, ahcl_reg, {H{1'b0}}}
                     + {{H{1'b0}}, alch_reg, {H{1'b0}}}
                     + {{AW{1'b0}}, alcl_reg};
            a6_reg  <= a5_reg;
            nb6_reg <= nb5_reg;

            d_reg   <= nb2_reg - ac_reg;
            a7_reg  <= a6_reg;
            nb7_reg <= nb6_reg;
        end
    end

    assign ctl_o = c7_reg;
    assign d_o   = d_reg;
    assign nb_o  = nb7_reg;
    assign a_o   = a7_reg;

endmodule

// ===== hdl/mcct_sqrt_cell.sv =====
// One cell of the square root chain: settles one root bit per cell.
// Depends on mcct_pkg.
module mcct_sqrt_cell #(
    parameter int DW   = 68,
    parameter int RB   = 50,
    parameter int STEP = 0,
    parameter int SW   = 68
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  mcct_pkg::ctl_t ctl_i,
    input  logic [DW-1:0]  d_i,
    input  logic [RB:0]    rem_i,
    input  logic [RB-1:0]  root_i,
    input  logic [SW-1:0]  side_i,
    output mcct_pkg::ctl_t ctl_o,
    output logic [DW-1:0]  d_o,
    output logic [RB:0]    rem_o,
    output logic [RB-1:0]  root_o,
    output logic [SW-1:0]  side_o
);
    // radicand is d with 2*FRAC_BITS zero bits appended
    localparam int ZB = 2 * mcct_pkg::FRAC_BITS;
    localparam int HI = 2 * RB - 1 - 2 * STEP;

    mcct_pkg::ctl_t ctl_reg;
    logic [DW-1:0]  d_reg;
    logic [RB:0]    rem_reg, rem_next;
    logic [RB-1:0]  root_reg, root_next;
    logic [SW-1:0]  side_reg;
    logic [1:0]     pair;
    logic [RB+2:0]  rem_sh, trial, rem_diff;
    logic           ge;

    generate
        if (HI >= ZB) begin : g_data
            assign pair = d_i[HI-ZB -: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end
    endgenerate

    always_comb begin
        rem_sh    = {rem_i, pair};
        trial     = {1'b0, root_i, 2'b01};
        ge        = rem_sh >= trial;
        rem_diff  = rem_sh - trial;
        // the remainder never exceeds twice the root, so the top bits are zero
        rem_next  = ge ? rem_diff[RB:0] : rem_sh[RB:0];
        root_next = {root_i[RB-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= d_i;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_i;
        end
    end

    assign ctl_o  = ctl_reg;
    assign d_o    = d_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;
    assign side_o = side_reg;

endmodule

// ===== hdl/mcct_div_cell.sv =====
// One cell of the divider chain: one restoring quotient bit per cell.
// Depends on mcct_pkg.
module mcct_div_cell #(
    parameter int AW    = 34,
    parameter int DV    = 59,
    parameter int SHIFT = 0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  mcct_pkg::ctl_t                  ctl_i,
    input  logic [AW-1:0]                   a_i,
    input  logic [DV-1:0]                   rem_i,
    input  logic [mcct_pkg::TIME_WIDTH:0]   q_i,
    output mcct_pkg::ctl_t                  ctl_o,
    output logic [AW-1:0]                   a_o,
    output logic [DV-1:0]                   rem_o,
    output logic [mcct_pkg::TIME_WIDTH:0]   q_o
);
    localparam int TW = mcct_pkg::TIME_WIDTH;

    mcct_pkg::ctl_t ctl_reg;
    logic [AW-1:0]  a_reg;
    logic [DV-1:0]  rem_reg, dsh;
    logic [TW:0]    q_reg;
    logic           ge;

    always_comb begin
        dsh = {{(DV-AW){1'b0}}, a_i} << SHIFT;
        ge  = rem_i >= dsh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg   <= a_i;
            rem_reg <= ge ? (rem_i - dsh) : rem_i;
            q_reg   <= {q_i[TW-1:0], ge};
        end
    end

    assign ctl_o = ctl_reg;
    assign a_o   = a_reg;
    assign rem_o = rem_reg;
    assign q_o   = q_reg;

endmodule

// ===== bench/mcct_checker.sv =====
// Checker for the moving circle contact time block: watches both stream channels,
// predicts the outcome of each accepted word and compares the results in order.
// Depends on mcct_pkg for the outcome codes.
`timescale 1ns / 100ps

module mcct_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [159:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [23:0]  m_tdata,
    input  logic [3:0]   m_tuser,
    output int           fail_count,
    output int           pending,
    output int           contact_count,
    output int           result_count
);
    typedef struct {
        logic                hit;
        mcct_pkg::outcome_t  outcome;
        logic [23:0]         time_first;
    } sweep_result_t;

    sweep_result_t expected_results[$];

    function automatic sweep_result_t sweep_test(logic [159:0] w);
        longint sx, sy, vx, vy, rs, c, a, b;
        logic [127:0] nb, nb2, ac, d, root, cand, n, q;
        sweep_result_t r;
        sx = longint'($signed(w[15:0])) - longint'($signed(w[62:47]));
        sy = longint'($signed(w[31:16])) - longint'($signed(w[78:63]));
        vx = longint'($signed(w[141:126])) - longint'($signed(w[109:94]));
        vy = longint'($signed(w[157:142])) - longint'($signed(w[125:110]));
        rs = longint'(w[46:32]) + longint'(w[93:79]);
        c = sx * sx + sy * sy - rs * rs;
        a = vx * vx + vy * vy;
        b = vx * sx + vy * sy;
        r.hit = 1'b0;
        r.time_first = '0;
        if (c < 0) begin
            r.hit = 1'b1;
            r.outcome = mcct_pkg::OUT_OVERLAP;
        end else if (a == 0) begin
            r.outcome = mcct_pkg::OUT_NO_MOTION;
        end else if (b >= 0) begin
            r.outcome = mcct_pkg::OUT_SEPARATING;
        end else begin
            nb = 128'(-b);
            nb2 = nb * nb;
            ac = 128'(a) * 128'(c);
            if (nb2 < ac) begin
                r.outcome = mcct_pkg::OUT_NO_ROOT;
            end else begin
                // root of the discriminant with 16 fraction bits, truncated
                d = (nb2 - ac) << 32;
                root = '0;
                for (int k = 63; k >= 0; k--) begin
                    cand = root | (128'(1) << k);
                    if (cand * cand <= d)
                        root = cand;
                end
                n = (nb << 16) - root;
                q = n / 128'(a);
                r.hit = 1'b1;
                r.outcome = mcct_pkg::OUT_CONTACT;
                r.time_first = (q > 128'hFFFFFF) ? 24'hFFFFFF : q[23:0];
            end
        end
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        sweep_result_t exp_r;
        if (!aresetn) begin
            fail_count = 0;
            contact_count = 0;
            result_count = 0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(sweep_test(s_tdata));
            if (m_tvalid && m_tready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: tuser %h tdata %h",
                           m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.outcome == mcct_pkg::OUT_CONTACT)
                        contact_count++;
                    if (m_tuser[0] !== exp_r.hit) begin
                        $error("hit: expected %0d, got %0d", exp_r.hit, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[3:1] !== exp_r.outcome) begin
                        $error("outcome: expected %0d, got %0d", exp_r.outcome, m_tuser[3:1]);
                        fail_count++;
                    end
                    if (m_tdata !== exp_r.time_first) begin
                        $error("time_first: expected %0d, got %0d", exp_r.time_first, m_tdata);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_moving_circle_contact_time.sv =====
// Testbench top for moving_circle_contact_time: drives directed and random circle
// pairs with random idling on both sides. Depends on mcct_pkg and mcct_checker.
`timescale 1ns / 100ps

module tb_moving_circle_contact_time;
    localparam int N_RANDOM   = 400;
    localparam int QUIET_FROM = 340;
    localparam int DRAIN_WAIT = 120;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic [3:0]   m_tuser;

    int  fail_count, pending, contact_count, result_count;
    int  words_sent = 0;
    bit  quiet = 1'b0;
    bit  hold_receiver = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    moving_circle_contact_time u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    mcct_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending),
        .contact_count(contact_count), .result_count(result_count)
    );

    function automatic logic [159:0] pack_pair(
        int ox, int oy, int orad, int px, int py, int prad,
        int ax, int ay, int bx, int by);
        logic [159:0] w;
        w = '0;
        w[15:0]    = 16'(ox);
        w[31:16]   = 16'(oy);
        w[46:32]   = 15'(orad);
        w[62:47]   = 16'(px);
        w[78:63]   = 16'(py);
        w[93:79]   = 15'(prad);
        w[109:94]  = 16'(ax);
        w[125:110] = 16'(ay);
        w[141:126] = 16'(bx);
        w[157:142] = 16'(by);
        return w;
    endfunction

    function automatic int spread(int lim);
        return $urandom_range(2 * lim) - lim;
    endfunction

    task automatic send_word(logic [159:0] w);
        s_tvalid <= 1'b1;
        s_tdata <= w;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (!quiet && $urandom_range(3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        bit held;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_receiver && !held) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                held = 1'b1;
            end else if (!quiet && $urandom_range(3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    initial begin
        #5ms;
        $display("timeout with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int ox, oy, px, py, dx, dy, vx, vy, ax, ay, rr;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // overlap at start
        send_word(pack_pair(0, 0, 16, 16, 0, 16, 0, 0, 0, 0));
        // touching at start, no relative motion
        send_word(pack_pair(0, 0, 16, 32, 0, 16, 0, 0, 0, 0));
        // all zero: touching, no motion
        send_word(pack_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // moving apart
        send_word(pack_pair(0, 0, 16, 320, 0, 16, 0, 0, -16, 0));
        // contact ahead, then a closing pair that misses (no root)
        send_word(pack_pair(0, 0, 16, 320, 0, 16, 0, 0, 16, 0));
        send_word(pack_pair(0, 0, 16, 320, 0, 16, 40, -7, 56, 3));
        // closing but passing wide
        send_word(pack_pair(0, 0, 16, 320, 0, 16, 0, 0, 16, 160));
        // saturated time: far apart, slowest closing speed; then far apart, moving apart
        send_word(pack_pair(-32768, 0, 0, 32767, 0, 0, 0, 0, 1, 0));
        send_word(pack_pair(-32768, -32768, 0, 32767, 32767, 0, 32767, 32767,
                            -32768, -32768));
        // field extremes
        send_word(pack_pair(32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 32767, 32767, 32767));
        send_word(pack_pair(-32768, -32768, 0, -32768, -32768, 0,
                            -32768, -32768, -32768, -32768));
        send_word(pack_pair(32767, -32768, 32767, -32768, 32767, 32767,
                            -32768, 32767, 32767, -32768));
        send_word(pack_pair(32767, 32767, 0, -32768, -32768, 0,
                            -32768, -32768, 32767, 32767));
        send_word(pack_pair(-32768, 32767, 1, 32767, -32768, 1,
                            32767, -32768, -32768, 32767));

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == QUIET_FROM)
                quiet = 1'b1;
            if (i == 120)
                hold_receiver = 1'b1;
            // pause the sender until the pipeline has drained
            if (i == 250) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending != 0);
            end
            if ($urandom_range(9) < 3) begin
                send_word({2'b00, 158'({$urandom, $urandom, $urandom, $urandom, $urandom})});
            end else begin
                // aimed pair: relative motion roughly toward the other circle
                px = spread(20000);
                py = spread(20000);
                dx = spread(4000);
                dy = spread(4000);
                ox = px + dx;
                oy = py + dy;
                rr = $urandom_range(1, 8);
                vx = -dx / rr + spread(200);
                vy = -dy / rr + spread(200);
                ax = spread(10000);
                ay = spread(10000);
                send_word(pack_pair(ox, oy, $urandom_range(1000), px, py,
                                    $urandom_range(1000), ax, ay, ax + vx, ay + vy));
            end
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("sent %0d circle pairs, got %0d results, %0d of them contact ahead",
                 words_sent, result_count, contact_count);
        $display("covered every outcome, field extremes, saturation and stalls on both sides");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
